// ----- rtl/lpde_pkg.sv -----
// Shared types, constants and the reciprocal table for the Legendre evaluator.
// Used by lpde_ctrl, lpde_datapath and the top level; depends on nothing.
package lpde_pkg;

  // Number formats
  localparam int FRAC_BITS  = 30;
  localparam int MAX_DEGREE = 32;
  localparam int DEG_W      = 6;
  localparam int PT_W       = 32;
  localparam int OUT_W      = 48;

  // Internal widths: P values stay near +-1.0, the scaled term t below 2^37,
  // derivatives below 2^40.
  localparam int K_W      = 6;
  localparam int PW       = 34;
  localparam int TW       = 40;
  localparam int DW       = 48;
  localparam int MUL_OP_W = 32;
  localparam int MUL_W    = 2 * MUL_OP_W;
  localparam int ACC_W    = 70;
  localparam int RCP_W    = 30;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  // Input beat
  typedef struct packed {
    logic        [DEG_W-1:0] degree;
    logic signed [PT_W-1:0]  point;
  } item_t;

  // Result beat
  typedef struct packed {
    logic signed [OUT_W-1:0] leg_value;
    logic signed [OUT_W-1:0] leg_slope;
    logic signed [OUT_W-1:0] lobatto_q;
    logic signed [OUT_W-1:0] lobatto_q_slope;
    logic                    q_valid;
  } result_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULX,
    ST_TERM,
    ST_MULLO,
    ST_MULHI,
    ST_RND,
    ST_FIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul_x;
    logic term;
    logic mul_lo;
    logic mul_hi;
    logic rnd;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic deg_zero;
    logic last_step;
    logic out_free;
  } ctl_stat_t;

  // round(2^FRAC_BITS / k), half up; slots 0 and 1 are never read
  localparam logic [RCP_W-1:0] RECIP [0:MAX_DEGREE+1] = '{
    RCP_W'(0),
    RCP_W'(0),
    RCP_W'((ONE + 1) / 2),
    RCP_W'((ONE + 1) / 3),
    RCP_W'((ONE + 2) / 4),
    RCP_W'((ONE + 2) / 5),
    RCP_W'((ONE + 3) / 6),
    RCP_W'((ONE + 3) / 7),
    RCP_W'((ONE + 4) / 8),
    RCP_W'((ONE + 4) / 9),
    RCP_W'((ONE + 5) / 10),
    RCP_W'((ONE + 5) / 11),
    RCP_W'((ONE + 6) / 12),
    RCP_W'((ONE + 6) / 13),
    RCP_W'((ONE + 7) / 14),
    RCP_W'((ONE + 7) / 15),
    RCP_W'((ONE + 8) / 16),
    RCP_W'((ONE + 8) / 17),
    RCP_W'((ONE + 9) / 18),
    RCP_W'((ONE + 9) / 19),
    RCP_W'((ONE + 10) / 20),
    RCP_W'((ONE + 10) / 21),
    RCP_W'((ONE + 11) / 22),
    RCP_W'((ONE + 11) / 23),
    RCP_W'((ONE + 12) / 24),
    RCP_W'((ONE + 12) / 25),
    RCP_W'((ONE + 13) / 26),
    RCP_W'((ONE + 13) / 27),
    RCP_W'((ONE + 14) / 28),
    RCP_W'((ONE + 14) / 29),
    RCP_W'((ONE + 15) / 30),
    RCP_W'((ONE + 15) / 31),
    RCP_W'((ONE + 16) / 32),
    RCP_W'((ONE + 16) / 33)
  };

endpackage

// ----- rtl/lpde_ctrl.sv -----
// Sequencer for the Legendre recurrence: five states per recurrence step.
// Depends on lpde_pkg for the state, command and status types.
module lpde_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  lpde_pkg::ctl_stat_t stat,
  output lpde_pkg::ctl_cmd_t  cmd
);

  lpde_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpde_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lpde_pkg::ST_IDLE:  if (item_valid) state_next = lpde_pkg::ST_MULX;
      lpde_pkg::ST_MULX:  state_next = stat.deg_zero ? lpde_pkg::ST_FIN : lpde_pkg::ST_TERM;
      lpde_pkg::ST_TERM:  state_next = lpde_pkg::ST_MULLO;
      lpde_pkg::ST_MULLO: state_next = lpde_pkg::ST_MULHI;
      lpde_pkg::ST_MULHI: state_next = lpde_pkg::ST_RND;
      lpde_pkg::ST_RND:   state_next = stat.last_step ? lpde_pkg::ST_FIN : lpde_pkg::ST_MULX;
      lpde_pkg::ST_FIN:   if (stat.out_free) state_next = lpde_pkg::ST_IDLE;
      default:            state_next = lpde_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      lpde_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        cmd.load   = item_valid;
      end
      lpde_pkg::ST_MULX:  cmd.mul_x  = 1'b1;
      lpde_pkg::ST_TERM:  cmd.term   = 1'b1;
      lpde_pkg::ST_MULLO: cmd.mul_lo = 1'b1;
      lpde_pkg::ST_MULHI: cmd.mul_hi = 1'b1;
      lpde_pkg::ST_RND:   cmd.rnd    = 1'b1;
      lpde_pkg::ST_FIN:   cmd.emit   = stat.out_free;
      default:            cmd        = '0;
    endcase
  end

endmodule

// ----- rtl/lpde_datapath.sv -----
// Datapath for the Legendre recurrence: operand registers, one shared 32x32
// multiplier, rounding, result capture and the output register. Uses lpde_pkg.
module lpde_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lpde_pkg::item_t     item,
  input  lpde_pkg::ctl_cmd_t  cmd,
  output lpde_pkg::ctl_stat_t stat,
  output logic                result_valid,
  input  logic                result_stall,
  output lpde_pkg::result_t   result
);

  localparam logic signed [lpde_pkg::PT_W-1:0] ONE_PT = lpde_pkg::PT_W'(lpde_pkg::ONE);
  localparam logic signed [lpde_pkg::PT_W-1:0] NEG_ONE_PT = -ONE_PT;
  localparam logic [lpde_pkg::ACC_W-1:0] ROUND_HALF =
    lpde_pkg::ACC_W'(1) << (lpde_pkg::FRAC_BITS - 1);

  // Working registers
  logic        [lpde_pkg::K_W-1:0]   deg;
  logic        [lpde_pkg::K_W-1:0]   k;
  logic signed [lpde_pkg::PT_W-1:0]  x;
  logic signed [lpde_pkg::PW-1:0]    p1, p2;
  logic signed [lpde_pkg::DW-1:0]    d1, d2;
  logic        [lpde_pkg::MUL_W-1:0] prod;
  logic                              prod_neg;
  logic signed [lpde_pkg::TW-1:0]    t;
  logic        [lpde_pkg::ACC_W-1:0] acc;
  logic signed [lpde_pkg::OUT_W-1:0] res_leg, res_slope, res_q, res_qs;

  // Combinational values
  logic        [lpde_pkg::K_W-1:0]    deg_sat;
  logic signed [lpde_pkg::PT_W-1:0]   x_sat;
  logic        [lpde_pkg::PT_W-1:0]   x_mag;
  logic        [lpde_pkg::PW-1:0]     p1_mag;
  logic        [lpde_pkg::TW-1:0]     t_mag;
  logic        [lpde_pkg::RCP_W-1:0]  recip_k;
  logic        [lpde_pkg::MUL_OP_W-1:0] mul_a, mul_b;
  logic        [lpde_pkg::MUL_W-1:0]  mul_prod;
  logic        [lpde_pkg::K_W:0]      k_odd;
  logic        [lpde_pkg::K_W-1:0]    k_less;
  logic        [lpde_pkg::PW-1:0]     m1_mag;
  logic signed [lpde_pkg::TW-1:0]     m1_t, odd_t, kless_t, p2_t, t_next;
  logic        [lpde_pkg::TW-1:0]     pk_mag;
  logic signed [lpde_pkg::PW-1:0]     pk;
  logic signed [lpde_pkg::DW-1:0]     odd_d, p1_d, dk;

  // Clamp degree and point on entry
  always_comb begin
    deg_sat = (item.degree > lpde_pkg::K_W'(lpde_pkg::MAX_DEGREE)) ?
              lpde_pkg::K_W'(lpde_pkg::MAX_DEGREE) : item.degree;
    if (item.point > ONE_PT) begin
      x_sat = ONE_PT;
    end else if (item.point < NEG_ONE_PT) begin
      x_sat = NEG_ONE_PT;
    end else begin
      x_sat = item.point;
    end
  end

  // Magnitudes for the sign-magnitude multiplies
  assign x_mag  = x[lpde_pkg::PT_W-1] ? lpde_pkg::PT_W'(-x) : lpde_pkg::PT_W'(x);
  assign p1_mag = p1[lpde_pkg::PW-1] ? lpde_pkg::PW'(-p1) : lpde_pkg::PW'(p1);
  assign t_mag  = t[lpde_pkg::TW-1] ? lpde_pkg::TW'(-t) : lpde_pkg::TW'(t);
  assign recip_k = lpde_pkg::RECIP[k];

  // Shared multiplier operand select
  always_comb begin
    if (cmd.mul_lo) begin
      mul_a = t_mag[lpde_pkg::MUL_OP_W-1:0];
      mul_b = lpde_pkg::MUL_OP_W'(recip_k);
    end else if (cmd.mul_hi) begin
      mul_a = lpde_pkg::MUL_OP_W'(t_mag[lpde_pkg::TW-1:lpde_pkg::MUL_OP_W]);
      mul_b = lpde_pkg::MUL_OP_W'(recip_k);
    end else begin
      mul_a = x_mag;
      mul_b = p1_mag[lpde_pkg::MUL_OP_W-1:0];
    end
  end
  assign mul_prod = lpde_pkg::MUL_W'(mul_a) * lpde_pkg::MUL_W'(mul_b);

  // Three-term combination: t = (2k-1) * round(x*P1) - (k-1) * P2
  always_comb begin
    k_odd   = {k, 1'b0} - (lpde_pkg::K_W+1)'(1);
    k_less  = k - lpde_pkg::K_W'(1);
    m1_mag  = lpde_pkg::PW'(prod[lpde_pkg::MUL_W-1:lpde_pkg::FRAC_BITS]) +
              lpde_pkg::PW'(prod[lpde_pkg::FRAC_BITS-1]);
    m1_t    = prod_neg ? -lpde_pkg::TW'(m1_mag) : lpde_pkg::TW'(m1_mag);
    odd_t   = lpde_pkg::TW'(k_odd);
    kless_t = lpde_pkg::TW'(k_less);
    p2_t    = lpde_pkg::TW'(p2);
    t_next  = odd_t * m1_t - kless_t * p2_t;
  end

  // Rounded P_k and the derivative update
  always_comb begin
    pk_mag = lpde_pkg::TW'(acc[lpde_pkg::ACC_W-1:lpde_pkg::FRAC_BITS]);
    pk     = t[lpde_pkg::TW-1] ? -lpde_pkg::PW'(pk_mag) : lpde_pkg::PW'(pk_mag);
    odd_d  = lpde_pkg::DW'(k_odd);
    p1_d   = lpde_pkg::DW'(p1);
    dk     = d2 + odd_d * p1_d;
  end

  // Status
  assign stat.deg_zero  = (deg == '0);
  assign stat.last_step = ({1'b0, k} == ({1'b0, deg} + (lpde_pkg::K_W+1)'(1)));
  assign stat.out_free  = !result_valid || !result_stall;

  // Recurrence registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      deg       <= deg_sat;
      x         <= x_sat;
      p2        <= lpde_pkg::PW'(lpde_pkg::ONE);
      p1        <= lpde_pkg::PW'(x_sat);
      d2        <= '0;
      d1        <= lpde_pkg::DW'(lpde_pkg::ONE);
      k         <= lpde_pkg::K_W'(2);
      res_leg   <= lpde_pkg::OUT_W'(lpde_pkg::ONE);
      res_slope <= '0;
      res_q     <= '0;
      res_qs    <= '0;
    end
    if (cmd.mul_x) begin
      prod     <= mul_prod;
      prod_neg <= x[lpde_pkg::PT_W-1] ^ p1[lpde_pkg::PW-1];
    end
    if (cmd.term) begin
      t <= t_next;
    end
    if (cmd.mul_lo) begin
      acc <= lpde_pkg::ACC_W'(mul_prod) + ROUND_HALF;
    end
    if (cmd.mul_hi) begin
      acc <= acc + (lpde_pkg::ACC_W'(mul_prod) << lpde_pkg::MUL_OP_W);
    end
    if (cmd.rnd) begin
      p2 <= p1;
      p1 <= pk;
      d2 <= d1;
      d1 <= dk;
      if (stat.last_step) begin
        // capture P_n, P_n' and the Lobatto pair at step n+1
        res_leg   <= lpde_pkg::OUT_W'(p1);
        res_slope <= lpde_pkg::OUT_W'(d1);
        res_q     <= lpde_pkg::OUT_W'(pk) - lpde_pkg::OUT_W'(p2);
        res_qs    <= lpde_pkg::OUT_W'(dk - d2);
      end else begin
        k <= k + lpde_pkg::K_W'(1);
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.leg_value       <= res_leg;
      result.leg_slope       <= res_slope;
      result.lobatto_q       <= res_q;
      result.lobatto_q_slope <= res_qs;
      result.q_valid         <= (deg != '0);
    end
  end

endmodule

// ----- rtl/legendre_poly_and_derivative_eval_top.sv -----
// Legendre polynomial and derivative evaluator, top level.
// Instantiates lpde_ctrl and lpde_datapath; types come from lpde_pkg.
//
// Usage:
//   The item channel takes a degree n and a point x (Q2.30). A beat is taken
//   when item_valid is high and item_stall is low. The result channel gives
//   P_n(x), P_n'(x), the Lobatto pair P_{n+1}-P_{n-1} and its derivative, and
//   q_valid, all Q.30 in 48 bits; a beat moves when result_valid is high and
//   result_stall is low.
//   Degree is clamped to 32 and x to [-1, 1] on entry.
//   An item of degree n >= 1 runs the recurrence before the output register
//   loads; an item of degree zero skips it. Each recurrence step uses the
//   single 32x32 multiplier three times (x*P, then the low and high halves
//   of t*(1/k)), and also forms t and rounds the new P_k.
//   The item channel stalls while an item is in work. A finished result sits
//   in the output register; if the receiver stalls, the block holds the next
//   finished result until the register frees, and the beat held does not
//   change. Synchronous reset returns to idle and empties the output register.
module legendre_poly_and_derivative_eval_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  lpde_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output lpde_pkg::result_t   result
);

  lpde_pkg::ctl_cmd_t  cmd;
  lpde_pkg::ctl_stat_t stat;

  // Sequencer
  lpde_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Arithmetic and output register
  lpde_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
